// File: hdl/fisd_pkg.sv
// fisd_pkg: shared constants and helpers for the reciprocal square root pipeline
// used by fisd_fmul, fisd_fsub and fast_inverse_sqrt_double; depends on nothing
`default_nettype none

package fisd_pkg;

   // number of refinement iterations applied to the seed
   localparam int NEWTON_STEPS = 2;

   // pipeline depths of the arithmetic units, in register stages
   localparam int FMUL_LAT = 6;
   localparam int FSUB_LAT = 6;
   localparam int STEP_LAT = 3 * FMUL_LAT + FSUB_LAT;

   localparam logic [63:0] SEED_MAGIC  = 64'h5fe6_eb50_c7b5_37a9;
   localparam logic [63:0] HALF_BITS   = 64'h3fe0_0000_0000_0000;
   localparam logic [63:0] THREE_HALF  = 64'h3ff8_0000_0000_0000;
   localparam logic [63:0] DEFAULT_NAN = 64'hfff8_0000_0000_0000;
   localparam logic [10:0] EXP_MAX     = 11'h7ff;
   localparam logic [51:0] QUIET_BIT   = 52'h8_0000_0000_0000;

   function automatic logic is_nan(input logic [63:0] v);
      return (v[62:52] == EXP_MAX) && (v[51:0] != 52'd0);
   endfunction

   function automatic logic is_inf(input logic [63:0] v);
      return (v[62:52] == EXP_MAX) && (v[51:0] == 52'd0);
   endfunction

   function automatic logic is_zero(input logic [63:0] v);
      return v[62:0] == 63'd0;
   endfunction

   function automatic logic [63:0] quiet(input logic [63:0] v);
      return {v[63:52], v[51:0] | QUIET_BIT};
   endfunction

   // leading zero count of the 106-bit product
   function automatic logic [6:0] lzc106(input logic [105:0] v);
      logic [6:0] c;
      c = 7'd106;
      for (int i = 0; i < 106; i++) begin
         if (v[i]) c = 7'(105 - i);
      end
      return c;
   endfunction

   // leading zero count of the 57-bit sum
   function automatic logic [5:0] lzc57(input logic [56:0] v);
      logic [5:0] c;
      c = 6'd57;
      for (int i = 0; i < 57; i++) begin
         if (v[i]) c = 6'(56 - i);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: hdl/fisd_fmul.sv
// fisd_fmul: six-stage pipelined binary64 multiplier, round to nearest even
// depends on fisd_pkg
`default_nettype none

module fisd_fmul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire logic        in_valid,
   input  wire logic [63:0] a_bits,
   input  wire logic [63:0] b_bits,
   output logic             out_valid,
   output logic [63:0]      out_bits
);
   import fisd_pkg::*;

   // stage 1: unpack, partial products, special cases
   logic        s1_valid_ff, s1_sign_ff, s1_spec_ff;
   logic [63:0] s1_spec_val_ff;
   logic [12:0] s1_esum_ff;
   logic [53:0] s1_hh_ff;
   logic [52:0] s1_hl_ff, s1_lh_ff;
   logic [51:0] s1_ll_ff;

   logic        sign_in, spec_in;
   logic [63:0] spec_val_in;
   logic [52:0] ma, mb;
   logic [11:0] eua, eub;

   always_comb begin
      sign_in = a_bits[63] ^ b_bits[63];
      ma  = {a_bits[62:52] != 11'd0, a_bits[51:0]};
      mb  = {b_bits[62:52] != 11'd0, b_bits[51:0]};
      eua = (a_bits[62:52] == 11'd0) ? 12'd1 : {1'b0, a_bits[62:52]};
      eub = (b_bits[62:52] == 11'd0) ? 12'd1 : {1'b0, b_bits[62:52]};
      spec_in = 1'b1;
      spec_val_in = 64'd0;
      priority if (is_nan(a_bits)) begin
         spec_val_in = quiet(a_bits);
      end else if (is_nan(b_bits)) begin
         spec_val_in = quiet(b_bits);
      end else if ((is_inf(a_bits) && is_zero(b_bits)) ||
                   (is_zero(a_bits) && is_inf(b_bits))) begin
         spec_val_in = DEFAULT_NAN;
      end else if (is_inf(a_bits) || is_inf(b_bits)) begin
         spec_val_in = {sign_in, EXP_MAX, 52'd0};
      end else if (is_zero(a_bits) || is_zero(b_bits)) begin
         spec_val_in = {sign_in, 63'd0};
      end else begin
         spec_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
      if (advance) begin
         s1_sign_ff     <= sign_in;
         s1_spec_ff     <= spec_in;
         s1_spec_val_ff <= spec_val_in;
         s1_esum_ff     <= {1'b0, eua} + {1'b0, eub};
         s1_hh_ff       <= {27'd0, ma[52:26]} * {27'd0, mb[52:26]};
         s1_hl_ff       <= {26'd0, ma[52:26]} * {27'd0, mb[25:0]};
         s1_lh_ff       <= {27'd0, ma[25:0]} * {26'd0, mb[52:26]};
         s1_ll_ff       <= {26'd0, ma[25:0]} * {26'd0, mb[25:0]};
      end
   end

   // stage 2: cross terms
   logic        s2_valid_ff, s2_sign_ff, s2_spec_ff;
   logic [63:0] s2_spec_val_ff;
   logic [12:0] s2_esum_ff;
   logic [53:0] s2_hh_ff, s2_mid_ff;
   logic [51:0] s2_ll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_sign_ff     <= s1_sign_ff;
         s2_spec_ff     <= s1_spec_ff;
         s2_spec_val_ff <= s1_spec_val_ff;
         s2_esum_ff     <= s1_esum_ff;
         s2_hh_ff       <= s1_hh_ff;
         s2_mid_ff      <= {1'b0, s1_hl_ff} + {1'b0, s1_lh_ff};
         s2_ll_ff       <= s1_ll_ff;
      end
   end

   // stage 3: full product
   logic         s3_valid_ff, s3_sign_ff, s3_spec_ff;
   logic [63:0]  s3_spec_val_ff;
   logic [12:0]  s3_esum_ff;
   logic [105:0] s3_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_sign_ff     <= s2_sign_ff;
         s3_spec_ff     <= s2_spec_ff;
         s3_spec_val_ff <= s2_spec_val_ff;
         s3_esum_ff     <= s2_esum_ff;
         s3_prod_ff     <= ({52'd0, s2_hh_ff} << 52) + ({52'd0, s2_mid_ff} << 26)
                           + {54'd0, s2_ll_ff};
      end
   end

   // stage 4: leading zero count, exponent and normalize amount
   logic               s4_valid_ff, s4_sign_ff, s4_spec_ff;
   logic [63:0]        s4_spec_val_ff;
   logic [105:0]       s4_prod_ff;
   logic signed [13:0] s4_exp_ff, s4_shift_ff;

   logic [6:0]         lz;
   logic signed [13:0] exp_in, shift_in;

   always_comb begin
      lz = lzc106(s3_prod_ff);
      exp_in = $signed({1'b0, s3_esum_ff}) - $signed({7'd0, lz}) - 14'sd1022;
      if (exp_in >= 14'sd1) begin
         shift_in = $signed({7'd0, lz});
      end else begin
         shift_in = $signed({7'd0, lz}) + exp_in - 14'sd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s4_sign_ff     <= s3_sign_ff;
         s4_spec_ff     <= s3_spec_ff;
         s4_spec_val_ff <= s3_spec_val_ff;
         s4_prod_ff     <= s3_prod_ff;
         s4_exp_ff      <= exp_in;
         s4_shift_ff    <= shift_in;
      end
   end

   // stage 5: normalize or denormalize, rounding decision
   logic        s5_valid_ff, s5_sign_ff, s5_spec_ff, s5_ovf_ff, s5_inc_ff;
   logic [63:0] s5_spec_val_ff;
   logic [62:0] s5_base_ff;

   logic [105:0] norm;
   logic [211:0] ext;
   logic [13:0]  rsh;
   logic [7:0]   rsh_cl;
   logic         extra;
   logic [10:0]  expf;

   always_comb begin
      rsh = 14'(-s4_shift_ff);
      rsh_cl = (rsh > 14'd107) ? 8'd107 : rsh[7:0];
      ext = {s4_prod_ff, 106'd0} >> rsh_cl;
      if (!s4_shift_ff[13]) begin
         norm  = s4_prod_ff << s4_shift_ff[6:0];
         extra = 1'b0;
      end else begin
         norm  = ext[211:106];
         extra = |ext[105:0];
      end
      expf = norm[105] ? s4_exp_ff[10:0] : 11'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (advance) begin
         s5_sign_ff     <= s4_sign_ff;
         s5_spec_ff     <= s4_spec_ff;
         s5_spec_val_ff <= s4_spec_val_ff;
         s5_ovf_ff      <= s4_exp_ff >= 14'sd2047;
         s5_base_ff     <= {expf, norm[104:53]};
         s5_inc_ff      <= norm[52] & ((|norm[51:0]) | extra | norm[53]);
      end
   end

   // stage 6: round and select
   logic        out_valid_ff;
   logic [63:0] out_bits_ff, out_bits_in;

   always_comb begin
      priority if (s5_spec_ff) begin
         out_bits_in = s5_spec_val_ff;
      end else if (s5_ovf_ff) begin
         out_bits_in = {s5_sign_ff, EXP_MAX, 52'd0};
      end else begin
         out_bits_in = {s5_sign_ff, s5_base_ff + {62'd0, s5_inc_ff}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s5_valid_ff;
      end
      if (advance) begin
         out_bits_ff <= out_bits_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_bits  = out_bits_ff;

endmodule

`default_nettype wire

// File: hdl/fisd_fsub.sv
// fisd_fsub: six-stage pipelined binary64 subtractor a - b, round to nearest even
// depends on fisd_pkg
`default_nettype none

module fisd_fsub (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire logic        in_valid,
   input  wire logic [63:0] a_bits,
   input  wire logic [63:0] b_bits,
   output logic             out_valid,
   output logic [63:0]      out_bits
);
   import fisd_pkg::*;

   // stage 1: unpack, order by magnitude, special cases
   logic        s1_valid_ff, s1_sign_ff, s1_sub_ff, s1_zsign_ff, s1_spec_ff;
   logic [63:0] s1_spec_val_ff;
   logic [11:0] s1_exu_ff, s1_diff_ff;
   logic [52:0] s1_mx_ff, s1_my_ff;

   logic        sb_eff, a_big, spec_in;
   logic [63:0] spec_val_in, x_bits, y_bits;
   logic [11:0] exu, eyu;

   always_comb begin
      sb_eff = ~b_bits[63];
      a_big  = a_bits[62:0] >= b_bits[62:0];
      x_bits = a_big ? a_bits : {sb_eff, b_bits[62:0]};
      y_bits = a_big ? {sb_eff, b_bits[62:0]} : a_bits;
      exu = (x_bits[62:52] == 11'd0) ? 12'd1 : {1'b0, x_bits[62:52]};
      eyu = (y_bits[62:52] == 11'd0) ? 12'd1 : {1'b0, y_bits[62:52]};
      spec_in = 1'b1;
      spec_val_in = 64'd0;
      priority if (is_nan(a_bits)) begin
         spec_val_in = quiet(a_bits);
      end else if (is_nan(b_bits)) begin
         spec_val_in = quiet(b_bits);
      end else if (is_inf(a_bits) && is_inf(b_bits) && (a_bits[63] != sb_eff)) begin
         spec_val_in = DEFAULT_NAN;
      end else if (is_inf(a_bits)) begin
         spec_val_in = a_bits;
      end else if (is_inf(b_bits)) begin
         spec_val_in = {sb_eff, EXP_MAX, 52'd0};
      end else begin
         spec_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
      if (advance) begin
         s1_sign_ff     <= x_bits[63];
         s1_sub_ff      <= x_bits[63] ^ y_bits[63];
         s1_zsign_ff    <= a_bits[63] & sb_eff;
         s1_spec_ff     <= spec_in;
         s1_spec_val_ff <= spec_val_in;
         s1_exu_ff      <= exu;
         s1_diff_ff     <= exu - eyu;
         s1_mx_ff       <= {x_bits[62:52] != 11'd0, x_bits[51:0]};
         s1_my_ff       <= {y_bits[62:52] != 11'd0, y_bits[51:0]};
      end
   end

   // stage 2: align the smaller operand with sticky
   logic        s2_valid_ff, s2_sign_ff, s2_sub_ff, s2_zsign_ff, s2_spec_ff;
   logic [63:0] s2_spec_val_ff;
   logic [11:0] s2_exu_ff;
   logic [55:0] s2_mx_ff, s2_my_ff;

   logic [5:0]   dcl;
   logic [111:0] aext;

   always_comb begin
      dcl  = (s1_diff_ff > 12'd57) ? 6'd57 : s1_diff_ff[5:0];
      aext = {s1_my_ff, 3'd0, 56'd0} >> dcl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_sign_ff     <= s1_sign_ff;
         s2_sub_ff      <= s1_sub_ff;
         s2_zsign_ff    <= s1_zsign_ff;
         s2_spec_ff     <= s1_spec_ff;
         s2_spec_val_ff <= s1_spec_val_ff;
         s2_exu_ff      <= s1_exu_ff;
         s2_mx_ff       <= {s1_mx_ff, 3'd0};
         s2_my_ff       <= {aext[111:57], aext[56] | (|aext[55:0])};
      end
   end

   // stage 3: add or subtract magnitudes
   logic        s3_valid_ff, s3_sign_ff, s3_zsign_ff, s3_spec_ff;
   logic [63:0] s3_spec_val_ff;
   logic [11:0] s3_exu_ff;
   logic [56:0] s3_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_sign_ff     <= s2_sign_ff;
         s3_zsign_ff    <= s2_zsign_ff;
         s3_spec_ff     <= s2_spec_ff;
         s3_spec_val_ff <= s2_spec_val_ff;
         s3_exu_ff      <= s2_exu_ff;
         s3_sum_ff      <= s2_sub_ff ? ({1'b0, s2_mx_ff} - {1'b0, s2_my_ff})
                                     : ({1'b0, s2_mx_ff} + {1'b0, s2_my_ff});
      end
   end

   // stage 4: leading zero count, exponent and normalize amount
   logic               s4_valid_ff, s4_sign_ff, s4_zsign_ff, s4_spec_ff, s4_zero_ff;
   logic [63:0]        s4_spec_val_ff;
   logic [56:0]        s4_sum_ff;
   logic signed [13:0] s4_exp_ff;
   logic [5:0]         s4_shift_ff;

   logic [5:0]         lz;
   logic signed [13:0] exp_in;

   always_comb begin
      lz = lzc57(s3_sum_ff);
      exp_in = $signed({2'd0, s3_exu_ff}) + 14'sd1 - $signed({8'd0, lz});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s4_sign_ff     <= s3_sign_ff;
         s4_zsign_ff    <= s3_zsign_ff;
         s4_spec_ff     <= s3_spec_ff;
         s4_spec_val_ff <= s3_spec_val_ff;
         s4_zero_ff     <= s3_sum_ff == 57'd0;
         s4_sum_ff      <= s3_sum_ff;
         s4_exp_ff      <= exp_in;
         s4_shift_ff    <= (exp_in >= 14'sd1) ? lz : s3_exu_ff[5:0];
      end
   end

   // stage 5: normalize, rounding decision
   logic        s5_valid_ff, s5_sign_ff, s5_zsign_ff, s5_spec_ff, s5_zero_ff;
   logic        s5_ovf_ff, s5_inc_ff;
   logic [63:0] s5_spec_val_ff;
   logic [62:0] s5_base_ff;

   logic [56:0] norm;
   logic [10:0] expf;

   always_comb begin
      norm = s4_sum_ff << s4_shift_ff;
      expf = norm[56] ? s4_exp_ff[10:0] : 11'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (advance) begin
         s5_sign_ff     <= s4_sign_ff;
         s5_zsign_ff    <= s4_zsign_ff;
         s5_spec_ff     <= s4_spec_ff;
         s5_spec_val_ff <= s4_spec_val_ff;
         s5_zero_ff     <= s4_zero_ff;
         s5_ovf_ff      <= s4_exp_ff >= 14'sd2047;
         s5_base_ff     <= {expf, norm[55:4]};
         s5_inc_ff      <= norm[3] & ((|norm[2:0]) | norm[4]);
      end
   end

   // stage 6: round and select
   logic        out_valid_ff;
   logic [63:0] out_bits_ff, out_bits_in;

   always_comb begin
      priority if (s5_spec_ff) begin
         out_bits_in = s5_spec_val_ff;
      end else if (s5_zero_ff) begin
         out_bits_in = {s5_zsign_ff, 63'd0};
      end else if (s5_ovf_ff) begin
         out_bits_in = {s5_sign_ff, EXP_MAX, 52'd0};
      end else begin
         out_bits_in = {s5_sign_ff, s5_base_ff + {62'd0, s5_inc_ff}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s5_valid_ff;
      end
      if (advance) begin
         out_bits_ff <= out_bits_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_bits  = out_bits_ff;

endmodule

`default_nettype wire

// File: hdl/fast_inverse_sqrt_double.sv
// fast_inverse_sqrt_double: approximate binary64 reciprocal square root
// depends on fisd_pkg, fisd_fmul and fisd_fsub
//
// usage:
//  - a transaction on req_ carries one binary64 operand as raw bits; each one
//    yields exactly one transaction on rsp_ with the result bits, in order
//  - the seed is formed by an integer subtract, then each refinement step runs
//    three multipliers and one subtractor back to back
//  - a result passes the half multiplier, the refinement steps and the result
//    register; throughput is one transaction per cycle while the skid is empty
//  - the result register is backed by one skid register; req_ready drops only
//    when both hold results, so a stalled receiver still leaves room for one
//    more result and the whole pipeline freezes without loss or repeat
//  - synchronous reset clears all valid bits; nothing is in flight afterward
`default_nettype none

module fast_inverse_sqrt_double (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_operand_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_result_bits
);
   import fisd_pkg::*;

   logic advance;

   // per-step pipeline taps: y estimate, half operand, valid
   logic [63:0] y_tap [0:NEWTON_STEPS];
   logic [63:0] h_tap [0:NEWTON_STEPS];
   logic        v_tap [0:NEWTON_STEPS];

   // integer seed from the operand bits
   logic [63:0] seed;
   assign seed = SEED_MAGIC - {req_operand_bits[63], req_operand_bits[63:1]};

   // half operand
   fisd_fmul u_half (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid & advance),
      .a_bits    (req_operand_bits),
      .b_bits    (HALF_BITS),
      .out_valid (v_tap[0]),
      .out_bits  (h_tap[0])
   );

   // seed delay to line up with the half operand
   logic [63:0] seed_dly_ff [0:FMUL_LAT-1];

   always_ff @(posedge clock) begin
      if (advance) begin
         seed_dly_ff[0] <= seed;
         for (int i = 1; i < FMUL_LAT; i++) seed_dly_ff[i] <= seed_dly_ff[i-1];
      end
   end

   assign y_tap[0] = seed_dly_ff[FMUL_LAT-1];

   // refinement steps: y * (1.5 - (h * y) * y)
   for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
      logic        p1_valid, p2_valid, df_valid;
      logic [63:0] p1_bits, p2_bits, df_bits;
      logic [63:0] ya_dly_ff [0:FMUL_LAT-1];
      logic [63:0] yb_dly_ff [0:FMUL_LAT+FSUB_LAT-1];
      logic [63:0] h_dly_ff  [0:STEP_LAT-1];

      // y copies for the second and last multiply, h for the next step
      always_ff @(posedge clock) begin
         if (advance) begin
            ya_dly_ff[0] <= y_tap[k];
            for (int i = 1; i < FMUL_LAT; i++) ya_dly_ff[i] <= ya_dly_ff[i-1];
            yb_dly_ff[0] <= ya_dly_ff[FMUL_LAT-1];
            for (int i = 1; i < FMUL_LAT + FSUB_LAT; i++) yb_dly_ff[i] <= yb_dly_ff[i-1];
            h_dly_ff[0] <= h_tap[k];
            for (int i = 1; i < STEP_LAT; i++) h_dly_ff[i] <= h_dly_ff[i-1];
         end
      end

      fisd_fmul u_p1 (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (v_tap[k]),
         .a_bits    (h_tap[k]),
         .b_bits    (y_tap[k]),
         .out_valid (p1_valid),
         .out_bits  (p1_bits)
      );

      fisd_fmul u_p2 (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (p1_valid),
         .a_bits    (p1_bits),
         .b_bits    (ya_dly_ff[FMUL_LAT-1]),
         .out_valid (p2_valid),
         .out_bits  (p2_bits)
      );

      fisd_fsub u_df (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (p2_valid),
         .a_bits    (THREE_HALF),
         .b_bits    (p2_bits),
         .out_valid (df_valid),
         .out_bits  (df_bits)
      );

      fisd_fmul u_r (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (df_valid),
         .a_bits    (yb_dly_ff[FMUL_LAT+FSUB_LAT-1]),
         .b_bits    (df_bits),
         .out_valid (v_tap[k+1]),
         .out_bits  (y_tap[k+1])
      );

      assign h_tap[k+1] = h_dly_ff[STEP_LAT-1];
   end

   // result register with one skid entry
   logic        rsp_valid_ff, skid_valid_ff;
   logic [63:0] rsp_bits_ff, skid_bits_ff;
   logic        pipe_out, rsp_take;

   assign advance  = ~skid_valid_ff;
   assign pipe_out = advance & v_tap[NEWTON_STEPS];
   assign rsp_take = rsp_valid_ff & rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (rsp_take) begin
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (pipe_out) begin
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) rsp_bits_ff <= skid_bits_ff;
      end else if (pipe_out) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_bits_ff <= y_tap[NEWTON_STEPS];
         end else begin
            skid_bits_ff <= y_tap[NEWTON_STEPS];
         end
      end
   end

   assign req_ready       = advance;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_bits = rsp_bits_ff;

endmodule

`default_nettype wire

// File: tb/tb_fast_inverse_sqrt_double.sv
// tb_fast_inverse_sqrt_double: self-checking bench for the binary64 reciprocal square root
// depends on fisd_pkg and fast_inverse_sqrt_double; predicts each result with real arithmetic
`default_nettype none

// expected results in arrival order, predicted when an operand is accepted
class rsqrt_scoreboard;
   logic [63:0] expected_q[$];
   logic [63:0] operand_q[$];
   int          mismatches;
   int          extras;

   // integer seed, then separately rounded refinement steps
   function automatic logic [63:0] recip_sqrt_bits(input logic [63:0] n_bits);
      real         n, half_n, y, p1, p2, diff;
      logic [63:0] seed;
      n      = $bitstoreal(n_bits);
      half_n = n * 0.5;
      seed   = fisd_pkg::SEED_MAGIC - {n_bits[63], n_bits[63:1]};
      y      = $bitstoreal(seed);
      for (int k = 0; k < fisd_pkg::NEWTON_STEPS; k++) begin
         p1   = half_n * y;
         p2   = p1 * y;
         diff = 1.5 - p2;
         y    = y * diff;
      end
      return $realtobits(y);
   endfunction

   function void note_operand(input logic [63:0] n_bits);
      expected_q.push_back(recip_sqrt_bits(n_bits));
      operand_q.push_back(n_bits);
   endfunction

   function void check_result(input logic [63:0] got);
      logic [63:0] want, op;
      if (expected_q.size() == 0) begin
         extras++;
         if (mismatches + extras <= 10)
            $display("unexpected result %h with nothing pending", got);
         return;
      end
      want = expected_q.pop_front();
      op   = operand_q.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches + extras <= 10)
            $display("operand %h: result_bits expected %h got %h", op, want, got);
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction
endclass

module tb_fast_inverse_sqrt_double;
   import fisd_pkg::*;

   localparam int RANDOM_ITEMS = 1350;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_operand_bits;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_result_bits;
   logic        no_idle;
   logic        reset_done;

   rsqrt_scoreboard sb;

   fast_inverse_sqrt_double dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operand_bits(req_operand_bits),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_bits(rsp_result_bits)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // pick an idle count for one transaction
   function automatic int idle_cycles();
      return no_idle ? 0 : $urandom_range(0, 4);
   endfunction

   // one transaction on the request side; valid stays high across back-to-back items
   task automatic send_operand(input logic [63:0] bits);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operand_bits <= bits;
      do @(posedge clock); while (!req_ready);
      sb.note_operand(bits);
   endtask

   // random operand, weighted toward well-scaled positive values
   function automatic logic [63:0] random_operand();
      logic [63:0] v;
      int          pick;
      pick = $urandom_range(0, 9);
      v    = {$urandom, $urandom};
      case (pick)
         0, 1, 2, 3, 4: begin
            v[63]    = 1'b0;
            v[62:52] = 11'($urandom_range(1023 - 60, 1023 + 60));
         end
         5, 6: ;
         7: v[63] = 1'b0;
         8: begin
            v[62:52] = 11'd0;
            if ($urandom_range(0, 3) == 0) v[51:0] = 52'd0;
         end
         default: begin
            v[62:52] = EXP_MAX;
            if ($urandom_range(0, 2) == 0) v[51:0] = 52'd0;
         end
      endcase
      return v;
   endfunction

   // response side: random stalls, checks every accepted result
   initial begin
      rsp_ready = 1'b0;
      wait (reset_done);
      forever begin
         int stall;
         stall = idle_cycles();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_result_bits);
      end
   end

   // directed corners, then random operands
   initial begin
      logic [63:0] corners[$];
      sb               = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operand_bits = 64'd0;
      no_idle          = 1'b0;
      reset_done       = 1'b0;
      repeat (7) @(posedge clock);
      reset      <= 1'b0;
      reset_done <= 1'b1;
      @(posedge clock);

      corners = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                  64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000,
                  64'h7ff8_0000_0000_0000, 64'h7ff0_0000_0000_0001,
                  64'hfff8_0000_0000_1234, 64'hffff_ffff_ffff_ffff,
                  64'h0000_0000_0000_0001, 64'h000f_ffff_ffff_ffff,
                  64'h0010_0000_0000_0000, 64'h7fef_ffff_ffff_ffff,
                  64'h3ff0_0000_0000_0000, 64'h4010_0000_0000_0000,
                  64'h3fd0_0000_0000_0000, 64'hbff0_0000_0000_0000,
                  64'h4000_0000_0000_0000, 64'h3fe0_0000_0000_0000,
                  64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                  64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0001};
      foreach (corners[i]) send_operand(corners[i]);

      // hold off until the pipeline drains once
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 200 == 0) no_idle <= ($urandom_range(0, 2) == 0);
         send_operand(random_operand());
      end
      req_valid <= 1'b0;

      // drain, then allow for any late extra result
      while (sb.pending() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
      if (sb.mismatches == 0 && sb.extras == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end
endmodule

`default_nettype wire
